// File: sv/annular_focus_delay_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the annular focus delay block
// Concurrent checks written in one house form, sampled on the rising edge
// and switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef ANNULAR_FOCUS_DELAY_TOP_DEFINES_SVH
`define ANNULAR_FOCUS_DELAY_TOP_DEFINES_SVH

// Same-cycle implication.
`define AFD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Widths, reset values, beat types and the square-root state shared by the
// annular focus delay block.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int INDEX_BITS = 16;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int RADIUS_W = 24;
  localparam int SPM_W    = 26;
  localparam int UPS_W    = 5;
  localparam int OUT_W    = INDEX_BITS + 1;
  localparam int CFG_W    = SPM_W;
  localparam int CFG_ADDR_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLES_PER_MM = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPSAMPLE       = 1'b1;

  localparam logic [SPM_W-1:0] SPM_RESET = SPM_W'(3407872);
  localparam logic [UPS_W-1:0] UPS_RESET = UPS_W'(1);
  localparam logic [OUT_W-1:0] OUT_MAX   = '1;

  // Depth index bits actually used.
  localparam int S_W    = (INDEX_BITS < SAMPLE_W) ? INDEX_BITS : SAMPLE_W;
  localparam int SSQ_W  = 2 * S_W;

  // Radius scaling: product is Q.32.
  localparam int FRAC_W  = 32;
  localparam int PROD_W  = RADIUS_W + SPM_W;
  localparam int RFULL_W = PROD_W + UPS_W;
  localparam int R8_FRAC = 8;
  localparam int R8_SHIFT = FRAC_W - R8_FRAC;
  localparam int RKEEP_W = FRAC_W + OUT_W;
  localparam int R8_W    = RKEEP_W - R8_SHIFT + 1;
  localparam logic [RKEEP_W:0] R8_RND = (RKEEP_W + 1)'(1) << (R8_SHIFT - 1);

  // Squared distance in Q.16.
  localparam int SSH_W = SSQ_W + 2 * R8_FRAC;
  localparam int RSQ_W = 2 * R8_W;
  localparam int X_W   = ((RSQ_W > SSH_W) ? RSQ_W : SSH_W) + 1;

  // Square root: four result bits per pipeline stage.
  localparam int Q_MIN     = (X_W + 3) / 2;
  localparam int SQ_PER    = 4;
  localparam int SQ_STAGES = (Q_MIN + SQ_PER - 1) / SQ_PER;
  localparam int Q_W       = SQ_STAGES * SQ_PER;
  localparam int V_W       = 2 * Q_W;
  localparam int REM_W     = Q_W + 2;

  // Final rounding of the doubled root.
  localparam int N_SHIFT = R8_FRAC + 1;
  localparam int N_W     = Q_W + 1 - N_SHIFT;
  localparam logic [Q_W:0] N_RND = (Q_W + 1)'(1) << R8_FRAC;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_index;
    logic [RADIUS_W-1:0] ring_radius_mm_q;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_W-1:0] focus_sample;
    logic             clipped;
  } out_beat_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   root;
    logic [V_W-1:0]   opnd;
  } sqrt_state_t;

endpackage

// File: sv/annular_focus_delay_top.sv
// ----------------------------------------------------------------------------
// annular_focus_delay_top
// Dynamic receive-focus delay for one ring of an annular transducer.
// ----------------------------------------------------------------------------
// Each input beat carries a depth sample index and a ring radius in mm. The
// block scales the radius by the samples-per-mm register and the upsample
// factor, then returns the index of round-half-up(sqrt(s^2 + R^2)), saturated
// at the top of the output range with the clipped flag raised.
// The input channel (in_valid, in_ready, in_data) and the result channel
// (out_valid, out_ready, out_data) use valid/ready; a beat moves when both
// are high. The configuration port writes one register per cycle with
// cfg_we and should only be used while no beat is in flight.
// An accepted input beat reaches out_valid through five stages of multiply
// and rounding, seven square-root stages of four root bits each, and one
// output stage. One beat is accepted every cycle unless all stages stall.
// Every stage holds a valid bit; a stage loads whenever it is empty or its
// successor moves on, so a stalled receiver halts only the occupied stages
// and in_ready drops once every stage is full.
// Synchronous reset clears all valid bits and restores the register reset
// values (52.0 samples per mm, upsample factor one).
// ----------------------------------------------------------------------------
`include "annular_focus_delay_top_defines.svh"

module annular_focus_delay_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  afd_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output afd_pkg::out_beat_t                  out_data,
  input  logic                                cfg_we,
  input  logic [afd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [afd_pkg::CFG_W-1:0]           cfg_wdata
);
  import afd_pkg::*;

  // Stage map: 0 radius product, 1 upsample scaling, 2 clip and rounding,
  // 3 squaring, 4 sum, 5.. square root, last output.
  localparam int ST_SQ0    = 4;
  localparam int N_STAGES  = SQ_STAGES + 6;
  localparam int ST_OUT    = N_STAGES - 1;

  // Configuration registers.
  logic [SPM_W-1:0] spm_r;
  logic [UPS_W-1:0] ups_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r <= SPM_RESET;
      ups_r <= UPS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SAMPLES_PER_MM: spm_r <= cfg_wdata[SPM_W-1:0];
        CFG_UPSAMPLE:       ups_r <= cfg_wdata[UPS_W-1:0];
        default:            ;
      endcase
    end
  end

  // Valid bits and the load enables. A stage loads when it is empty or
  // when the stage after it is loading, so bubbles are squeezed out.
  logic [N_STAGES-1:0] v_r;
  logic [N_STAGES:0]   rdy;

  always_comb begin
    rdy[N_STAGES] = out_ready;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 0: radius times samples per mm, and the depth index squared.
  logic [PROD_W-1:0] prod_r;
  logic [SSQ_W-1:0]  ssq0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod_r <= PROD_W'(in_data.ring_radius_mm_q) * PROD_W'(spm_r);
      ssq0_r <= SSQ_W'(in_data.sample_index[S_W-1:0]) *
                SSQ_W'(in_data.sample_index[S_W-1:0]);
    end
  end

  // Stage 1: upsample scaling gives R in Q.32.
  logic [RFULL_W-1:0] rfull_r;
  logic [SSQ_W-1:0]   ssq1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      rfull_r <= RFULL_W'(prod_r) * RFULL_W'(ups_r);
      ssq1_r  <= ssq0_r;
    end
  end

  // Stage 2: an integer part beyond the output range clips; otherwise round
  // R half up to eight fraction bits.
  logic [RKEEP_W:0] rsum;
  logic [R8_W-1:0]  r8_r;
  logic             clip2_r;
  logic [SSQ_W-1:0] ssq2_r;

  assign rsum = {1'b0, rfull_r[RKEEP_W-1:0]} + R8_RND;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      r8_r    <= rsum[RKEEP_W:R8_SHIFT];
      clip2_r <= |rfull_r[RFULL_W-1:RKEEP_W];
      ssq2_r  <= ssq1_r;
    end
  end

  // Stage 3: square the rounded offset; align s^2 to Q.16.
  logic [RSQ_W-1:0] rsq_r;
  logic [SSH_W-1:0] ssh_r;
  logic             clip3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rsq_r   <= RSQ_W'(r8_r) * RSQ_W'(r8_r);
      ssh_r   <= {ssq2_r, (2 * R8_FRAC)'(0)};
      clip3_r <= clip2_r;
    end
  end

  // Stage 4 loads the square-root state with 4X; the following stages each
  // develop four root bits.
  logic [X_W-1:0] x_sum;
  sqrt_state_t    st_r    [0:SQ_STAGES];
  sqrt_state_t    st_nxt  [0:SQ_STAGES-1];
  logic           sclip_r [0:SQ_STAGES];

  assign x_sum = X_W'(rsq_r) + X_W'(ssh_r);

  always_ff @(posedge clk) begin
    if (rdy[ST_SQ0]) begin
      st_r[0].rem  <= '0;
      st_r[0].root <= '0;
      st_r[0].opnd <= V_W'({x_sum, 2'b00});
      sclip_r[0]   <= clip3_r;
    end
  end

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    afd_sqrt_step u_step (
      .st_i (st_r[j]),
      .st_o (st_nxt[j])
    );

    always_ff @(posedge clk) begin
      if (rdy[ST_SQ0+1+j]) begin
        st_r[j+1]    <= st_nxt[j];
        sclip_r[j+1] <= sclip_r[j];
      end
    end
  end

  // Output stage: the root is twice the distance with eight fraction bits,
  // so adding a half and dropping nine bits rounds the distance half up.
  logic [Q_W:0]   nsum;
  logic [N_W-1:0] n_val;
  logic           clip_all;
  out_beat_t      out_r;

  assign nsum     = {1'b0, st_r[SQ_STAGES].root} + N_RND;
  assign n_val    = nsum[Q_W:N_SHIFT];
  assign clip_all = sclip_r[SQ_STAGES] || (|n_val[N_W-1:OUT_W]);

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_r.focus_sample <= clip_all ? OUT_MAX : n_val[OUT_W-1:0];
      out_r.clipped      <= clip_all;
    end
  end

  assign out_valid = v_r[ST_OUT];
  assign out_data  = out_r;

  // Checks.
  `AFD_ASSERT_IMPLY(a_clip_saturates, clk, rst_n,
    out_valid && out_data.clipped, out_data.focus_sample == OUT_MAX,
    "clipped result is not saturated")
  `AFD_ASSERT_IMPLY(a_sqrt_rem_bound, clk, rst_n,
    v_r[ST_OUT-1], (st_r[SQ_STAGES].rem >> 1) <= REM_W'(st_r[SQ_STAGES].root),
    "square-root remainder exceeds twice the root")
  `AFD_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n,
    !in_ready, &v_r,
    "input stalled while a pipeline stage is empty")
  `AFD_ASSERT_NEXT(a_accept_fills_first, clk, rst_n,
    in_valid && in_ready, v_r[0],
    "accepted beat did not enter the first stage")

endmodule

// File: sv/afd_sqrt_step.sv
// ----------------------------------------------------------------------------
// afd_sqrt_step
// One stage of the restoring square root: develops four root bits from the
// next eight operand bits.
// ----------------------------------------------------------------------------
module afd_sqrt_step (
  input  afd_pkg::sqrt_state_t st_i,
  output afd_pkg::sqrt_state_t st_o
);
  import afd_pkg::*;

  always_comb begin
    sqrt_state_t      st;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    st = st_i;
    for (int i = 0; i < SQ_PER; i++) begin
      rem2  = {st.rem[REM_W-3:0], st.opnd[V_W-1:V_W-2]};
      trial = {st.root, 2'b01};
      if (rem2 >= trial) begin
        st.rem  = rem2 - trial;
        st.root = {st.root[Q_W-2:0], 1'b1};
      end else begin
        st.rem  = rem2;
        st.root = {st.root[Q_W-2:0], 1'b0};
      end
      st.opnd = {st.opnd[V_W-3:0], 2'b00};
    end
    st_o = st;
  end

endmodule

// File: tb/tb_annular_focus_delay_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_annular_focus_delay_top
// Self-checking bench for the annular focus delay block. A bit-exact model of
// the radius scaling, the rounding and the square root predicts each result.
// The bench runs the block through several register settings and three
// handshake pressure modes, with directed corner beats and random traffic.
// ----------------------------------------------------------------------------
module tb_annular_focus_delay_top;
  import afd_pkg::*;

  // Pipeline depth given for the block, and the number of cycles without a
  // single beat moving on either channel after which the run is abandoned.
  localparam int LATENCY      = 13;
  localparam int STALL_LIMIT  = 4000;
  localparam int NUM_PHASES   = 7;
  localparam int RAND_PER_PHASE = 172;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of both registers, predicts the focus
  // sample for every accepted input beat and checks results in order.
  // --------------------------------------------------------------------------
  class focus_scoreboard;
    bit [SPM_W-1:0] spm_q;
    bit [UPS_W-1:0] ups_q;
    out_beat_t      expected_focus_q[$];
    int             errors;
    int             results_seen;

    function new();
      spm_q  = SPM_RESET;
      ups_q  = UPS_RESET;
      errors = 0;
      results_seen = 0;
    endfunction

    // Only the low bits of a wide write land in the register.
    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_SAMPLES_PER_MM) begin
        spm_q = val[SPM_W-1:0];
      end else if (idx == CFG_UPSAMPLE) begin
        ups_q = val[UPS_W-1:0];
      end
    endfunction

    // Integer square root by building the root one bit at a time.
    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] root;
      bit [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function out_beat_t predict_focus(in_beat_t beat);
      bit [63:0] s;
      bit [63:0] r32;
      bit [63:0] r8;
      bit [63:0] dist_sq;
      bit [63:0] root2;
      bit [63:0] n;
      bit [63:0] top;
      out_beat_t res;
      top = 64'(OUT_MAX);
      s   = 64'(beat.sample_index[S_W-1:0]);
      r32 = 64'(beat.ring_radius_mm_q) * 64'(spm_q) * 64'(ups_q);
      res.focus_sample = OUT_MAX;
      res.clipped      = 1'b1;
      if ((r32 >> FRAC_W) <= top) begin
        r8      = (r32 + (64'd1 << (R8_SHIFT - 1))) >> R8_SHIFT;
        dist_sq = ((s * s) << (2 * R8_FRAC)) + r8 * r8;
        root2   = int_sqrt(dist_sq << 2);
        n       = (root2 + (64'd1 << R8_FRAC)) >> N_SHIFT;
        if (n <= top) begin
          res.focus_sample = n[OUT_W-1:0];
          res.clipped      = 1'b0;
        end
      end
      return res;
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endfunction

    function void note_input(in_beat_t beat);
      expected_focus_q.push_back(predict_focus(beat));
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      results_seen++;
      if (expected_focus_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_focus_q.pop_front();
        if (got.focus_sample !== want.focus_sample)
          report($sformatf("result %0d focus_sample %0d, expected %0d",
                           results_seen, got.focus_sample, want.focus_sample));
        if (got.clipped !== want.clipped)
          report($sformatf("result %0d clipped %0b, expected %0b",
                           results_seen, got.clipped, want.clipped));
      end
    endfunction

    function int pending();
      return expected_focus_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's inputs. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // Percentages of cycles in which each side holds back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  focus_scoreboard sb = new();

  always #2 clk = ~clk;

  annular_focus_delay_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Result side. The handshake is judged on the values held just before the
  // edge; the ready for the next cycle is then chosen at random according to
  // the current pressure mode.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("tb_annular_focus_delay_top NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task is entered just after a rising edge and drives with
  // nonblocking assignments, so the block sees the new values at the next edge.
  // --------------------------------------------------------------------------

  // Offers one input beat, with optional idle cycles in front of it. Valid is
  // held, with the payload steady, until the beat is taken.
  task automatic send_beat(input in_beat_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sb.note_input(beat);
  endtask

  // Writes one register. The write enable is left high so that back-to-back
  // writes need no second assignment in one step; the caller lowers it.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // A value whose width is itself random, so that small, medium and full
  // magnitudes all turn up often.
  function automatic bit [31:0] spread(int max_w);
    return $urandom() & 32'((64'd1 << $urandom_range(0, max_w)) - 1);
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t beat;
    beat.sample_index     = SAMPLE_W'($urandom());
    beat.ring_radius_mm_q = RADIUS_W'($urandom());
    case ($urandom_range(0, 5))
      0: ;
      1: beat.ring_radius_mm_q = RADIUS_W'(spread(RADIUS_W));
      2: begin
        case ($urandom_range(0, 3))
          0: beat.sample_index = '0;
          1: beat.sample_index = SAMPLE_W'(1);
          2: beat.sample_index = '1;
          default: beat.sample_index = SAMPLE_W'({SAMPLE_W{1'b1}} - 1);
        endcase
        beat.ring_radius_mm_q = RADIUS_W'(spread(RADIUS_W));
      end
      3: begin
        beat.sample_index     = SAMPLE_W'($urandom_range(0, 255));
        beat.ring_radius_mm_q = RADIUS_W'(spread(RADIUS_W));
      end
      4: begin
        beat.sample_index     = SAMPLE_W'(spread(SAMPLE_W));
        beat.ring_radius_mm_q = RADIUS_W'(spread(RADIUS_W));
      end
      default: beat.ring_radius_mm_q = RADIUS_W'($urandom_range(0, 15));
    endcase
    return beat;
  endfunction

  function automatic in_beat_t mk_beat(int s, int rad);
    in_beat_t beat;
    beat.sample_index     = SAMPLE_W'(s);
    beat.ring_radius_mm_q = RADIUS_W'(rad);
    return beat;
  endfunction

  // Directed corner beats, matched to the register setting of each phase.
  task automatic send_directed(input int phase);
    case (phase)
      // Reset setting: extremes of both fields and alternating bit patterns.
      0: begin
        send_beat(mk_beat(0, 0));
        send_beat(mk_beat(65535, 0));
        send_beat(mk_beat(0, 24'hFFFFFF));
        send_beat(mk_beat(65535, 24'hFFFFFF));
        send_beat(mk_beat(1, 1));
        send_beat(mk_beat(32768, 24'h800000));
        send_beat(mk_beat(16'hAAAA, 24'h555555));
        send_beat(mk_beat(16'h5555, 24'hAAAAAA));
        send_beat(mk_beat(100, 24'h010000));
      end
      // One sample per mm: distances land on exact halves, so the
      // round-half-up step is exercised directly, plus a 3-4-5 triangle.
      1: begin
        send_beat(mk_beat(0, 24'h008000));
        send_beat(mk_beat(0, 24'h007FFF));
        send_beat(mk_beat(0, 24'h018000));
        send_beat(mk_beat(3, 24'h040000));
        send_beat(mk_beat(65535, 24'hFFFFFF));
      end
      // Largest samples per mm: the radius alone overflows the output range, sits
      // just below it, or stays in range while the distance overflows.
      2: begin
        send_beat(mk_beat(0, 24'hFFFFFF));
        send_beat(mk_beat(65535, 1));
        send_beat(mk_beat(0, 0));
        send_beat(mk_beat(0, 524284));
        send_beat(mk_beat(65535, 524284));
        send_beat(mk_beat(0, 524292));
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. Registers change only once the pipeline has drained, and
  // since every input beat yields exactly one result, an empty scoreboard
  // means the block is idle.
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] spm_val;
    logic [CFG_W-1:0] ups_val;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Sender light and receiver heavy first, then the reverse, then free run.
      if (phase < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 62;
      end else if (phase < 5) begin
        send_idle_pct = 62;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // The first phase runs on the reset values. Upper bits above the
      // upsample field are sometimes filled with junk to show they are dropped.
      if (phase > 0) begin
        case (phase)
          1: begin
            spm_val = CFG_W'(32'h0001_0000);
            ups_val = CFG_W'(1);
          end
          2: begin
            spm_val = '1;
            ups_val = CFG_W'(16);
          end
          3: begin
            spm_val = '0;
            ups_val = CFG_W'(($urandom() << UPS_W) | 31);
          end
          4: begin
            spm_val = CFG_W'($urandom());
            ups_val = CFG_W'($urandom() << UPS_W);
          end
          5: begin
            spm_val = CFG_W'($urandom());
            ups_val = CFG_W'($urandom_range(1, 16));
          end
          default: begin
            spm_val = CFG_W'(SPM_RESET);
            ups_val = CFG_W'(16);
          end
        endcase
        write_reg(CFG_SAMPLES_PER_MM, spm_val);
        write_reg(CFG_UPSAMPLE, ups_val);
        cfg_we <= 1'b0;
      end

      send_directed(phase);
      repeat (RAND_PER_PHASE) send_beat(random_beat());
      in_valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clk);
    end

    // Let any stray result show up before the verdict.
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("tb_annular_focus_delay_top OK");
    end else begin
      $display("tb_annular_focus_delay_top NOT OK");
    end
    $finish;
  end

endmodule
